/* design/scm_pkg.sv */
package scm_pkg;

    // Default number of fade-out slots.
    localparam int SCM_FADE_SLOTS = 8;

    // Input opcodes.
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_PLAY      = 2'd1;
    localparam logic [1:0] OP_STOP      = 2'd2;
    localparam logic [1:0] OP_FULL_STOP = 2'd3;

    // Result actions.
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_VOLUME = 2'd1;
    localparam logic [1:0] ACT_STOP   = 2'd2;

    // Configuration register indexes.
    localparam logic REG_FADE_STEP  = 1'b0;
    localparam logic REG_MAX_VOLUME = 1'b1;

    // Reset values and full-scale level, Q0.16.
    localparam logic [15:0] FADE_STEP_RESET  = 16'd655;
    localparam logic [15:0] MAX_VOLUME_RESET = 16'hFFFF;
    localparam logic [15:0] LEVEL_FULL       = 16'hFFFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] stream_id;
    } scm_in_t;

    typedef struct packed {
        logic [7:0]  target_id;
        logic [1:0]  action;
        logic [15:0] level;
        logic        last;
    } scm_out_t;

    // One fade table slot.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] level;
    } scm_entry_t;

    typedef enum logic [2:0] {
        TBL_NONE,
        TBL_APPEND,
        TBL_DROP,
        TBL_SET_LEVEL,
        TBL_CLEAR
    } scm_tbl_op_t;

    typedef struct packed {
        scm_tbl_op_t op;
        scm_entry_t  entry;
    } scm_tbl_cmd_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } scm_alu_mode_t;

    typedef struct packed {
        scm_alu_mode_t mode;
        logic [15:0]   a;
        logic [15:0]   b;
    } scm_alu_req_t;

    typedef struct packed {
        logic [15:0] value;
        logic        borrow;
        logic        zero;
    } scm_alu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PLAY_CHECK,
        ST_PUSH,
        ST_PLAY_SCAN,
        ST_PLAY_START,
        ST_PLAY_VOLUME,
        ST_TICK_CMP,
        ST_TICK_ADD,
        ST_TICK_FADE,
        ST_FSTOP_CUR,
        ST_FSTOP_FADE,
        ST_FINISH
    } scm_state_t;

endpackage

/* design/scm_alu.sv */
module scm_alu (
    input  scm_pkg::scm_alu_req_t req,
    output scm_pkg::scm_alu_rsp_t rsp
);
    import scm_pkg::*;

    logic [15:0] b_op;
    logic        carry_in;
    logic [16:0] result;

    // One 16-bit adder; subtraction adds the complement plus one.
    assign b_op     = (req.mode == ALU_SUB) ? ~req.b : req.b;
    assign carry_in = (req.mode == ALU_SUB);
    assign result   = {1'b0, req.a} + {1'b0, b_op} + {16'd0, carry_in};

    // Addition saturates at full scale; subtraction reports borrow and zero.
    always_comb
    begin
        rsp = '0;
        case (req.mode)
            ALU_ADD:
            begin
                rsp.value  = result[16] ? LEVEL_FULL : result[15:0];
                rsp.borrow = 1'b0;
            end
            ALU_SUB:
            begin
                rsp.value  = result[15:0];
                rsp.borrow = ~result[16];
            end
            default:
            begin
                rsp.value  = result[15:0];
                rsp.borrow = 1'b0;
            end
        endcase
        rsp.zero = (result[15:0] == 16'd0);
    end

endmodule

/* design/scm_fade_table.sv */
module scm_fade_table #(
    parameter int SLOTS = scm_pkg::SCM_FADE_SLOTS,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CNT_W = $clog2(SLOTS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  scm_pkg::scm_tbl_cmd_t cmd,
    input  logic [IDX_W-1:0]      cmd_idx,
    input  logic [IDX_W-1:0]      rd_idx,
    output scm_pkg::scm_entry_t   rd_entry,
    output logic [CNT_W-1:0]      count
);
    import scm_pkg::*;

    scm_entry_t       entries_reg  [SLOTS];
    scm_entry_t       entries_next [SLOTS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // The table stays packed: oldest slot at index 0, newest at count-1.
    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        case (cmd.op)
            TBL_APPEND:
            begin
                for (int j = 0; j < SLOTS; j++)
                begin
                    if (CNT_W'(j) == count_reg)
                    begin
                        entries_next[j] = cmd.entry;
                    end
                end
                count_next = count_reg + CNT_W'(1);
            end
            TBL_DROP:
            begin
                // Every slot above the dropped one moves down by one.
                for (int j = 0; j < SLOTS - 1; j++)
                begin
                    if (IDX_W'(j) >= cmd_idx)
                    begin
                        entries_next[j] = entries_reg[j + 1];
                    end
                end
                count_next = count_reg - CNT_W'(1);
            end
            TBL_SET_LEVEL:
            begin
                for (int j = 0; j < SLOTS; j++)
                begin
                    if (IDX_W'(j) == cmd_idx)
                    begin
                        entries_next[j].level = cmd.entry.level;
                    end
                end
            end
            TBL_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Slot contents are undefined until written and need no reset.
    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

    assign rd_entry = entries_reg[rd_idx];
    assign count    = count_reg;

    // The fill count never passes the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("fade table count above slot count");

    // An append only lands in a table with a free slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == TBL_APPEND) |-> (count_reg < CNT_W'(SLOTS)))
        else $error("append into a full fade table");

    // Drops and level updates only touch occupied slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == TBL_DROP || cmd.op == TBL_SET_LEVEL) |-> (CNT_W'(cmd_idx) < count_reg))
        else $error("fade table access beyond fill count");

endmodule

/* design/stream_crossfade_manager.sv */
// Crossfade manager: keeps one current stream and a table of FADE_SLOTS streams that are fading
// out, and turns tick, play, stop and full stop commands into start, set volume and stop
// transfers, the last transfer of each command flagged by last. One command is handled at a
// time and in_stall stays high until its final transfer has been handed to the output
// register. All id compares and level arithmetic go through one shared 16-bit add/subtract
// unit, and the fade table is walked one slot per cycle unless out_stall holds a result back.
module stream_crossfade_manager #(
    parameter int FADE_SLOTS = scm_pkg::SCM_FADE_SLOTS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  scm_pkg::scm_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output scm_pkg::scm_out_t out_data
);
    import scm_pkg::*;

    localparam int IDX_W = (FADE_SLOTS > 1) ? $clog2(FADE_SLOTS) : 1;
    localparam int CNT_W = $clog2(FADE_SLOTS + 1);

    scm_state_t       state_reg;
    scm_state_t       state_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic [1:0]       op_reg;
    logic [7:0]       id_reg;
    logic             found_reg;
    logic             found_next;
    logic [15:0]      lvl_reg;
    logic [15:0]      lvl_next;
    logic             cur_valid_reg;
    logic             cur_valid_next;
    logic [7:0]       cur_id_reg;
    logic [7:0]       cur_id_next;
    logic [15:0]      cur_level_reg;
    logic [15:0]      cur_level_next;
    logic [15:0]      fade_step_reg;
    logic [15:0]      max_volume_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    scm_out_t         out_data_reg;
    scm_out_t         out_data_next;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    scm_out_t         pend_data_reg;
    scm_out_t         pend_data_next;

    scm_alu_req_t     alu_req;
    scm_alu_rsp_t     alu_rsp;
    scm_tbl_cmd_t     tbl_cmd;
    logic [IDX_W-1:0] tbl_idx;
    logic [IDX_W-1:0] rd_idx;
    scm_entry_t       rd_entry;
    logic [CNT_W-1:0] tbl_count;
    logic [CNT_W-1:0] cnt_m1;

    logic             in_accept;
    logic             out_free;
    logic             emit_ok;
    logic             emit;
    scm_out_t         emit_item;
    logic             flush;
    logic             tbl_full;
    logic             tbl_empty;
    logic             k_zero;
    logic             k_last;
    logic             ids_equal;
    logic             cur_same;
    logic             rise_ok;
    logic             fade_gt;

    scm_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    scm_fade_table #(
        .SLOTS (FADE_SLOTS)
    ) u_fade_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (tbl_cmd),
        .cmd_idx  (tbl_idx),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .count    (tbl_count)
    );

    // Handshake and status terms.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_ok   = !pend_valid_reg || out_free;
    assign flush     = (state_reg == ST_FINISH) && pend_valid_reg && out_free;

    assign tbl_full  = (tbl_count == CNT_W'(FADE_SLOTS));
    assign tbl_empty = (tbl_count == '0);
    assign cnt_m1    = tbl_count - CNT_W'(1);
    assign k_zero    = (k_reg == '0);
    assign k_last    = (CNT_W'(k_reg) == cnt_m1);

    assign ids_equal = alu_rsp.zero;
    assign cur_same  = cur_valid_reg && alu_rsp.zero;
    assign rise_ok   = cur_valid_reg && alu_rsp.borrow;
    assign fade_gt   = !alu_rsp.borrow && !alu_rsp.zero;

    // The eviction on a push reads the oldest slot; every other walk reads slot k.
    assign rd_idx = (state_reg == ST_PUSH) ? '0 : k_reg;

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_req.mode = ALU_ADD;
        alu_req.a    = '0;
        alu_req.b    = '0;
        case (state_reg)
            ST_PLAY_CHECK:
            begin
                alu_req.mode = ALU_SUB;
                alu_req.a    = {8'd0, cur_id_reg};
                alu_req.b    = {8'd0, id_reg};
            end
            ST_PLAY_SCAN:
            begin
                alu_req.mode = ALU_SUB;
                alu_req.a    = {8'd0, rd_entry.id};
                alu_req.b    = {8'd0, id_reg};
            end
            ST_TICK_CMP:
            begin
                alu_req.mode = ALU_SUB;
                alu_req.a    = cur_level_reg;
                alu_req.b    = max_volume_reg;
            end
            ST_TICK_ADD:
            begin
                alu_req.mode = ALU_ADD;
                alu_req.a    = cur_level_reg;
                alu_req.b    = fade_step_reg;
            end
            ST_TICK_FADE:
            begin
                alu_req.mode = ALU_SUB;
                alu_req.a    = rd_entry.level;
                alu_req.b    = fade_step_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_data.opcode)
                        OP_TICK:      state_next = ST_TICK_CMP;
                        OP_PLAY:      state_next = ST_PLAY_CHECK;
                        OP_STOP:      state_next = cur_valid_reg ? ST_PUSH : ST_FINISH;
                        OP_FULL_STOP: state_next = ST_FSTOP_CUR;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PLAY_CHECK:
            begin
                if (cur_same)
                    state_next = ST_FINISH;
                else if (cur_valid_reg)
                    state_next = ST_PUSH;
                else if (tbl_empty)
                    state_next = ST_PLAY_START;
                else
                    state_next = ST_PLAY_SCAN;
            end
            ST_PUSH:
            begin
                if (!tbl_full)
                    state_next = (op_reg == OP_PLAY) ? ST_PLAY_SCAN : ST_FINISH;
            end
            ST_PLAY_SCAN:
            begin
                if (k_zero)
                    state_next = (found_reg || ids_equal) ? ST_FINISH : ST_PLAY_START;
            end
            ST_PLAY_START:
            begin
                if (emit_ok)
                    state_next = ST_PLAY_VOLUME;
            end
            ST_PLAY_VOLUME:
            begin
                if (emit_ok)
                    state_next = ST_FINISH;
            end
            ST_TICK_CMP:
            begin
                if (rise_ok)
                    state_next = ST_TICK_ADD;
                else
                    state_next = tbl_empty ? ST_FINISH : ST_TICK_FADE;
            end
            ST_TICK_ADD:
            begin
                if (emit_ok)
                    state_next = tbl_empty ? ST_FINISH : ST_TICK_FADE;
            end
            ST_TICK_FADE:
            begin
                if (emit_ok && k_zero)
                    state_next = ST_FINISH;
            end
            ST_FSTOP_CUR:
            begin
                if (!cur_valid_reg || emit_ok)
                    state_next = tbl_empty ? ST_FINISH : ST_FSTOP_FADE;
            end
            ST_FSTOP_FADE:
            begin
                if (emit_ok && k_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: table commands, current stream updates and results.
    always_comb
    begin
        k_next         = k_reg;
        found_next     = found_reg;
        lvl_next       = lvl_reg;
        cur_valid_next = cur_valid_reg;
        cur_id_next    = cur_id_reg;
        cur_level_next = cur_level_reg;
        tbl_cmd        = '0;
        tbl_cmd.op     = TBL_NONE;
        tbl_idx        = k_reg;
        emit           = 1'b0;
        emit_item      = '0;
        case (state_reg)
            ST_PLAY_CHECK:
            begin
                found_next = 1'b0;
                if (!cur_valid_reg && !tbl_empty)
                    k_next = cnt_m1[IDX_W-1:0];
            end
            ST_PUSH:
            begin
                if (tbl_full)
                begin
                    // Evict the oldest slot to make room.
                    if (emit_ok)
                    begin
                        emit                = 1'b1;
                        emit_item.target_id = rd_entry.id;
                        emit_item.action    = ACT_STOP;
                        tbl_cmd.op          = TBL_DROP;
                        tbl_idx             = '0;
                    end
                end
                else
                begin
                    tbl_cmd.op          = TBL_APPEND;
                    tbl_cmd.entry.id    = cur_id_reg;
                    tbl_cmd.entry.level = cur_level_reg;
                    cur_valid_next      = 1'b0;
                    cur_id_next         = '0;
                    cur_level_next      = '0;
                    k_next              = tbl_count[IDX_W-1:0];
                end
            end
            ST_PLAY_SCAN:
            begin
                // Newest to oldest: drop every copy, keep the oldest copy's level.
                if (ids_equal)
                begin
                    tbl_cmd.op = TBL_DROP;
                    found_next = 1'b1;
                    lvl_next   = rd_entry.level;
                end
                if (k_zero)
                begin
                    if (found_reg || ids_equal)
                    begin
                        cur_valid_next = 1'b1;
                        cur_id_next    = id_reg;
                        cur_level_next = ids_equal ? rd_entry.level : lvl_reg;
                    end
                end
                else
                begin
                    k_next = k_reg - IDX_W'(1);
                end
            end
            ST_PLAY_START:
            begin
                if (emit_ok)
                begin
                    emit                = 1'b1;
                    emit_item.target_id = id_reg;
                    emit_item.action    = ACT_START;
                    cur_valid_next      = 1'b1;
                    cur_id_next         = id_reg;
                    cur_level_next      = '0;
                end
            end
            ST_PLAY_VOLUME:
            begin
                if (emit_ok)
                begin
                    emit                = 1'b1;
                    emit_item.target_id = id_reg;
                    emit_item.action    = ACT_VOLUME;
                end
            end
            ST_TICK_CMP:
            begin
                if (!rise_ok && !tbl_empty)
                    k_next = cnt_m1[IDX_W-1:0];
            end
            ST_TICK_ADD:
            begin
                if (emit_ok)
                begin
                    emit                = 1'b1;
                    emit_item.target_id = cur_id_reg;
                    emit_item.action    = ACT_VOLUME;
                    emit_item.level     = alu_rsp.value;
                    cur_level_next      = alu_rsp.value;
                    if (!tbl_empty)
                        k_next = cnt_m1[IDX_W-1:0];
                end
            end
            ST_TICK_FADE:
            begin
                if (emit_ok)
                begin
                    emit                = 1'b1;
                    emit_item.target_id = rd_entry.id;
                    if (fade_gt)
                    begin
                        emit_item.action    = ACT_VOLUME;
                        emit_item.level     = alu_rsp.value;
                        tbl_cmd.op          = TBL_SET_LEVEL;
                        tbl_cmd.entry.level = alu_rsp.value;
                    end
                    else
                    begin
                        emit_item.action = ACT_STOP;
                        tbl_cmd.op       = TBL_DROP;
                    end
                    if (!k_zero)
                        k_next = k_reg - IDX_W'(1);
                end
            end
            ST_FSTOP_CUR:
            begin
                k_next = '0;
                if (cur_valid_reg && emit_ok)
                begin
                    emit                = 1'b1;
                    emit_item.target_id = cur_id_reg;
                    emit_item.action    = ACT_STOP;
                    cur_valid_next      = 1'b0;
                    cur_id_next         = '0;
                    cur_level_next      = '0;
                end
            end
            ST_FSTOP_FADE:
            begin
                if (emit_ok)
                begin
                    emit                = 1'b1;
                    emit_item.target_id = rd_entry.id;
                    emit_item.action    = ACT_STOP;
                    if (k_last)
                        tbl_cmd.op = TBL_CLEAR;
                    else
                        k_next = k_reg + IDX_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // One result is held back until the next one appears, so the final
    // result of a command can carry last when the command ends.
    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = pend_data_reg;
            end
            pend_valid_next = 1'b1;
            pend_data_next  = emit_item;
        end
        else if (flush)
        begin
            out_valid_next     = 1'b1;
            out_data_next      = pend_data_reg;
            out_data_next.last = 1'b1;
            pend_valid_next    = 1'b0;
        end
    end

    // Control and stream state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            found_reg      <= 1'b0;
            cur_valid_reg  <= 1'b0;
            cur_id_reg     <= '0;
            cur_level_reg  <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            found_reg      <= found_next;
            cur_valid_reg  <= cur_valid_next;
            cur_id_reg     <= cur_id_next;
            cur_level_reg  <= cur_level_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_step_reg  <= FADE_STEP_RESET;
            max_volume_reg <= MAX_VOLUME_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FADE_STEP:  fade_step_reg  <= cfg_data;
                REG_MAX_VOLUME: max_volume_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Command and result payloads.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg <= in_data.opcode;
            id_reg <= in_data.stream_id;
        end
        lvl_reg       <= lvl_next;
        out_data_reg  <= out_data_next;
        pend_data_reg <= pend_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // No result is left behind once the block is ready for a new command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held result left over in idle");

    // Table walks only visit occupied slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK_FADE || state_reg == ST_PLAY_SCAN || state_reg == ST_FSTOP_FADE)
        |-> (CNT_W'(k_reg) < tbl_count))
        else $error("table walk index beyond fill count");

    // The closing transfer of a command carries the last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        flush |=> (out_valid_reg && out_data_reg.last))
        else $error("final result of a command not marked last");

endmodule

/* verif/stream_crossfade_manager_test.sv */
`timescale 1ns / 100ps

module stream_crossfade_manager_test;
    import scm_pkg::*;

    localparam int SLOTS = SCM_FADE_SLOTS;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 24;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    scm_in_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    scm_out_t    out_data;

    // Commands waiting to be sent, and player commands the block still owes.
    scm_in_t  cmd_backlog[$];
    scm_out_t awaited_commands[$];
    scm_out_t step_commands[$];
    int       cmds_queued = 0;
    int       cmds_taken = 0;
    int       mismatches = 0;
    int       quiet_cycles = 0;

    // Shadow state of the crossfade manager.
    logic        live_on;
    logic [7:0]  live_id;
    logic [15:0] live_level;
    logic [7:0]  fading_ids[SLOTS];
    logic [15:0] fading_levels[SLOTS];
    int          fading_count;
    logic [15:0] step_reg;
    logic [15:0] ceiling_reg;

    // Idle pattern state for both sides.
    int send_gap = 0;
    int send_calm = 0;
    int stall_left = 0;
    int stall_calm = 0;

    stream_crossfade_manager DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic add_command(input logic [7:0] id, input logic [1:0] act,
                               input logic [15:0] lvl);
        scm_out_t c;
        c.target_id = id;
        c.action    = act;
        c.level     = lvl;
        c.last      = 1'b0;
        step_commands = {step_commands, c};
    endtask

    // Close the gap left by slot k; the table stays packed, oldest first.
    task automatic drop_slot(input int k);
        for (int j = k; j + 1 < fading_count; j++)
        begin
            fading_ids[j]    = fading_ids[j + 1];
            fading_levels[j] = fading_levels[j + 1];
        end
        fading_count--;
    endtask

    // Move the live stream into the fade table, evicting the oldest slot if full.
    task automatic retire_live();
        if (fading_count >= SLOTS)
        begin
            add_command(fading_ids[0], ACT_STOP, '0);
            drop_slot(0);
        end
        fading_ids[fading_count]    = live_id;
        fading_levels[fading_count] = live_level;
        fading_count++;
        live_on    = 1'b0;
        live_id    = '0;
        live_level = '0;
    endtask

    // Work out the player commands caused by one accepted transfer.
    task automatic crossfade_predict(input scm_in_t cmd);
        int          k;
        logic        found;
        logic [15:0] lvl;
        logic [16:0] sum;
        step_commands.delete();
        found = 1'b0;
        lvl   = '0;
        case (cmd.opcode)
            OP_TICK:
            begin
                if (live_on && live_level < ceiling_reg)
                begin
                    sum = {1'b0, live_level} + {1'b0, step_reg};
                    live_level = sum[16] ? LEVEL_FULL : sum[15:0];
                    add_command(live_id, ACT_VOLUME, live_level);
                end
                for (k = fading_count - 1; k >= 0; k--)
                begin
                    if (fading_levels[k] > step_reg)
                    begin
                        fading_levels[k] = fading_levels[k] - step_reg;
                        add_command(fading_ids[k], ACT_VOLUME, fading_levels[k]);
                    end
                    else
                    begin
                        add_command(fading_ids[k], ACT_STOP, '0);
                        drop_slot(k);
                    end
                end
            end
            OP_PLAY:
            begin
                if (!(live_on && live_id == cmd.stream_id))
                begin
                    if (live_on)
                        retire_live();
                    for (k = 0; k < fading_count && !found; k++)
                    begin
                        if (fading_ids[k] == cmd.stream_id)
                        begin
                            found = 1'b1;
                            lvl   = fading_levels[k];
                        end
                    end
                    // A stream still fading out is revived at its present level, silently.
                    if (found)
                    begin
                        for (k = fading_count - 1; k >= 0; k--)
                        begin
                            if (fading_ids[k] == cmd.stream_id)
                                drop_slot(k);
                        end
                    end
                    else
                    begin
                        add_command(cmd.stream_id, ACT_START, '0);
                        add_command(cmd.stream_id, ACT_VOLUME, '0);
                    end
                    live_on    = 1'b1;
                    live_id    = cmd.stream_id;
                    live_level = lvl;
                end
            end
            OP_STOP:
            begin
                if (live_on)
                    retire_live();
            end
            OP_FULL_STOP:
            begin
                if (live_on)
                    add_command(live_id, ACT_STOP, '0);
                live_on    = 1'b0;
                live_id    = '0;
                live_level = '0;
                for (k = 0; k < fading_count; k++)
                    add_command(fading_ids[k], ACT_STOP, '0);
                fading_count = 0;
            end
            default:
            begin
            end
        endcase
        if (step_commands.size() > 0)
            step_commands[step_commands.size() - 1].last = 1'b1;
        awaited_commands = {awaited_commands, step_commands};
    endtask

    // Input driver: sends the backlog with random gaps and predicts each accepted transfer.
    always @(posedge clk or negedge rst_n)
    begin : driver
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            in_data      <= '0;
            send_gap     = 0;
            live_on      = 1'b0;
            live_id      = '0;
            live_level   = '0;
            fading_count = 0;
            step_reg     = FADE_STEP_RESET;
            ceiling_reg  = MAX_VOLUME_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_FADE_STEP)
                    step_reg = cfg_data;
                else
                    ceiling_reg = cfg_data;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_valid)
                begin
                    crossfade_predict(in_data);
                    cmds_taken++;
                end
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    in_data  <= cmd_backlog.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: random stalls, and each transfer checked against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        scm_out_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_commands.size() == 0)
                begin
                    $error("unexpected transfer: target_id %0d action %0d level %0d last %0d",
                           out_data.target_id, out_data.action, out_data.level, out_data.last);
                    mismatches++;
                end
                else
                begin
                    want = awaited_commands.pop_front();
                    if (out_data.target_id !== want.target_id)
                    begin
                        $error("target_id: expected %0d, actual %0d",
                               want.target_id, out_data.target_id);
                        mismatches++;
                    end
                    if (out_data.action !== want.action)
                    begin
                        $error("action: expected %0d, actual %0d", want.action, out_data.action);
                        mismatches++;
                    end
                    if (out_data.level !== want.level)
                    begin
                        $error("level: expected %0d, actual %0d", want.level, out_data.level);
                        mismatches++;
                    end
                    if (out_data.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, out_data.last);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left = pick_gap(stall_calm);
            end
        end
    end

    // Watchdog: too long without any transfer on either side ends the run.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic queue_cmd(input logic [1:0] op, input logic [7:0] id);
        scm_in_t c;
        c.opcode    = op;
        c.stream_id = id;
        cmd_backlog = {cmd_backlog, c};
        cmds_queued++;
    endtask

    // Wait until every command is taken and answered, then let a silent play finish.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (cmds_taken != cmds_queued || awaited_commands.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [15:0] step_set[7];
        logic [15:0] ceiling_set[7];
        logic [1:0]  op;
        logic [7:0]  id;
        int          roll;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: silent commands, revive, eviction, busiest tick.
        queue_cmd(OP_TICK, 8'd0);
        queue_cmd(OP_PLAY, 8'd0);
        queue_cmd(OP_PLAY, 8'd0);
        queue_cmd(OP_TICK, 8'd0);
        queue_cmd(OP_PLAY, 8'd255);
        queue_cmd(OP_TICK, 8'd0);
        queue_cmd(OP_PLAY, 8'd7);
        queue_cmd(OP_PLAY, 8'd255);
        queue_cmd(OP_TICK, 8'd0);
        queue_cmd(OP_STOP, 8'd0);
        queue_cmd(OP_STOP, 8'd0);
        queue_cmd(OP_FULL_STOP, 8'd0);
        for (int i = 1; i <= SLOTS + 2; i++)
            queue_cmd(OP_PLAY, 8'(i));
        queue_cmd(OP_TICK, 8'd0);
        queue_cmd(OP_FULL_STOP, 8'd0);
        wait_drained();

        // Settings per random phase, extremes first.
        step_set[0] = 16'd0;      ceiling_set[0] = 16'd0;
        step_set[1] = 16'hFFFF;   ceiling_set[1] = 16'hFFFF;
        step_set[2] = 16'd40000;  ceiling_set[2] = 16'hFFFF;
        step_set[3] = 16'd1;      ceiling_set[3] = 16'hFFFF;
        step_set[4] = 16'($urandom_range(1, 5000));
        ceiling_set[4] = 16'($urandom_range(0, 65535));
        step_set[5] = 16'($urandom_range(0, 65535));
        ceiling_set[5] = 16'($urandom_range(0, 65535));
        step_set[6] = FADE_STEP_RESET; ceiling_set[6] = 16'd30000;

        for (int p = 0; p < 7; p++)
        begin
            write_reg(REG_FADE_STEP, step_set[p]);
            write_reg(REG_MAX_VOLUME, ceiling_set[p]);
            // A small pool of ids makes revives and a crowded table common.
            for (int i = 0; i < 41; i++)
            begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 6) == 0)
                    id = 8'($urandom_range(0, 255));
                else
                    id = 8'($urandom_range(0, 9));
                if (roll < 45)
                    op = OP_TICK;
                else if (roll < 83)
                    op = OP_PLAY;
                else if (roll < 96)
                    op = OP_STOP;
                else
                    op = OP_FULL_STOP;
                queue_cmd(op, id);
            end
            wait_drained();
        end

        if (mismatches == 0 && awaited_commands.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
